// ----- hdl/gaussian_blur_3x3_rgb_assert.svh -----
// ----------------------------------------------------------------------------
// Blur assertion macros
// Concurrent checks for the 3x3 blur block; empty under synthesis.
// ----------------------------------------------------------------------------
`ifndef GAUSSIAN_BLUR_3X3_RGB_ASSERT_SVH
`define GAUSSIAN_BLUR_3X3_RGB_ASSERT_SVH

`ifndef SYNTHESIS

// same-cycle implication
`define GB3_ASSERT_NOW(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("gb3 assertion failed");

// next-cycle implication
`define GB3_ASSERT_NEXT(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("gb3 assertion failed");

`else

`define GB3_ASSERT_NOW(name, clk, rst_n, ante, cons)
`define GB3_ASSERT_NEXT(name, clk, rst_n, ante, cons)

`endif

`endif

// ----- hdl/gb3_pkg.sv -----
// ----------------------------------------------------------------------------
// gb3_pkg
// Types, constants and helpers shared by the 3x3 blur block.
// ----------------------------------------------------------------------------
`default_nettype none

package gb3_pkg;

    localparam int MAX_WIDTH  = 1024;
    localparam int MAX_HEIGHT = 1024;

    localparam int DIM_W      = 11;                  // frame_width / frame_height
    localparam int COL_W      = $clog2(MAX_WIDTH);   // line store address
    localparam int ROW_W      = 11;
    localparam int WGT_W      = 16;
    localparam int CHAN_W     = 8;
    localparam int PIX_W      = 3 * CHAN_W;
    localparam int WORD_W     = 32;
    localparam int PROD_W     = CHAN_W + WGT_W;
    localparam int RSUM_W     = PROD_W + 2;
    localparam int TOTAL_W    = PROD_W + 4;
    localparam int FRAC_W     = 16;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    localparam logic [CHAN_W-1:0] ALPHA_OPAQUE = 8'hff;
    localparam logic [CHAN_W-1:0] CHAN_MAX     = 8'hff;

    localparam logic [WGT_W-1:0] RST_W_CORNER = 16'd4096;
    localparam logic [WGT_W-1:0] RST_W_EDGE   = 16'd8192;
    localparam logic [WGT_W-1:0] RST_W_CENTER = 16'd16384;
    localparam logic [DIM_W-1:0] RST_WIDTH    = 11'd800;
    localparam logic [DIM_W-1:0] RST_HEIGHT   = 11'd600;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_W_CORNER     = 3'd0,
        REG_W_EDGE       = 3'd1,
        REG_W_CENTER     = 3'd2,
        REG_FRAME_WIDTH  = 3'd3,
        REG_FRAME_HEIGHT = 3'd4
    } t_reg_idx;

    typedef logic [PIX_W-1:0]  t_pix;    // red 23:16, green 15:8, blue 7:0
    typedef logic [CHAN_W-1:0] t_chan;
    typedef logic [PROD_W-1:0] t_prod;
    typedef t_prod [2:0]       t_prod3;  // index 2 red, 1 green, 0 blue

    // window position flags of one item
    typedef struct packed {
        logic have;
        logic eof;
        logic top;
        logic bottom;
        logic left;
        logic right;
    } t_pos;

    typedef struct packed {
        logic valid;
        logic have;
        logic eof;
    } t_tag;

    typedef struct packed {
        t_chan red;
        t_chan green;
        t_chan blue;
        logic  eof;
    } t_res;

    function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v,
                                                   input logic [DIM_W-1:0] hi);
        logic [DIM_W-1:0] r;
        if (v < DIM_W'(3)) begin
            r = DIM_W'(3);
        end else if (v > hi) begin
            r = hi;
        end else begin
            r = v;
        end
        return r;
    endfunction

endpackage

`default_nettype wire

// ----- hdl/gb3_pix_in_if.sv -----
// ----------------------------------------------------------------------------
// gb3_pix_in_if
// Pixel request channel into the blur block.
// ----------------------------------------------------------------------------
`default_nettype none

interface gb3_pix_in_if import gb3_pkg::*; ();
    logic              valid;
    logic              ready;
    logic              command;
    logic [WORD_W-1:0] pixel_word;

    modport source (output valid, output command, output pixel_word, input ready);
    modport sink   (input valid, input command, input pixel_word, output ready);
endinterface

`default_nettype wire

// ----- hdl/gb3_pix_out_if.sv -----
// ----------------------------------------------------------------------------
// gb3_pix_out_if
// Blurred pixel request channel out of the blur block.
// ----------------------------------------------------------------------------
`default_nettype none

interface gb3_pix_out_if import gb3_pkg::*; ();
    logic        valid;
    logic        ready;
    logic [CHAN_W-1:0] red;
    logic [CHAN_W-1:0] green;
    logic [CHAN_W-1:0] blue;
    logic [CHAN_W-1:0] alpha;
    logic        end_of_frame;

    modport source (output valid, output red, output green, output blue, output alpha,
                    output end_of_frame, input ready);
    modport sink   (input valid, input red, input green, input blue, input alpha,
                    input end_of_frame, output ready);
endinterface

`default_nettype wire

// ----- hdl/gb3_line_store.sv -----
// ----------------------------------------------------------------------------
// gb3_line_store
// Two line memories: lower holds the previous line, upper the one before.
// ----------------------------------------------------------------------------
`default_nettype none

module gb3_line_store import gb3_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rd_en,
    input  logic [COL_W-1:0] i_rd_addr,
    input  t_pix             i_now,
    input  logic             i_wb_en,
    input  logic [COL_W-1:0] i_wb_addr,
    output t_pix             o_up,
    output t_pix             o_lo
);

    t_pix r_upper [MAX_WIDTH];
    t_pix r_lower [MAX_WIDTH];
    t_pix r_up_q;
    t_pix r_lo_q;

    // read-before-write: the incoming pixel replaces what was read
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_lo_q             <= r_lower[i_rd_addr];
            r_lower[i_rd_addr] <= i_now;
        end
    end

    // the line that moves up is written back from the registered lower read
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_up_q <= r_upper[i_rd_addr];
        end
        if (i_wb_en) begin
            r_upper[i_wb_addr] <= r_lo_q;
        end
    end

    assign o_up = r_up_q;
    assign o_lo = r_lo_q;

endmodule

`default_nettype wire

// ----- hdl/gb3_cell.sv -----
// ----------------------------------------------------------------------------
// gb3_cell
// One window tap: holds a pixel, passes it to its left neighbor and
// weights its three channels.
// ----------------------------------------------------------------------------
`default_nettype none

module gb3_cell import gb3_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_shift,
    input  logic             i_en,
    input  t_pix             i_pix,
    output t_pix             o_pix,
    input  logic [WGT_W-1:0] i_weight,
    input  logic             i_keep,
    output t_prod3           o_prod
);

    t_pix             r_pix;
    t_prod3           r_prod;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pix <= '0;
        end else if (i_shift) begin
            r_pix <= i_pix;
        end
    end

    // taps outside the frame contribute nothing; their pixel may be unwritten
    // line memory, so the product itself is forced to zero
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int k = 0; k < 3; k++) begin
                r_prod[k] <= i_keep ? PROD_W'(r_pix[k*CHAN_W +: CHAN_W]) * PROD_W'(i_weight)
                                    : '0;
            end
        end
    end

    assign o_pix  = r_pix;
    assign o_prod = r_prod;

endmodule

`default_nettype wire

// ----- hdl/gb3_sum.sv -----
// ----------------------------------------------------------------------------
// gb3_sum
// Adds the nine weighted taps per channel, drops the fraction and
// saturates to eight bits.
// ----------------------------------------------------------------------------
`default_nettype none

module gb3_sum import gb3_pkg::*; (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_en,
    input  t_tag           i_tag,
    input  t_prod3 [8:0]   i_prod,
    output t_res           o_res,
    output logic           o_push
);

    logic [RSUM_W-1:0] r_rsum [3][3];   // [row][channel]
    t_tag              r_tag;
    logic [TOTAL_W-1:0] total [3];
    t_chan             chan  [3];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tag <= '0;
        end else if (i_en) begin
            r_tag <= i_tag;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int r = 0; r < 3; r++) begin
                for (int k = 0; k < 3; k++) begin
                    r_rsum[r][k] <= RSUM_W'(i_prod[r*3][k]) + RSUM_W'(i_prod[r*3+1][k])
                                  + RSUM_W'(i_prod[r*3+2][k]);
                end
            end
        end
    end

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            total[k] = TOTAL_W'(r_rsum[0][k]) + TOTAL_W'(r_rsum[1][k])
                     + TOTAL_W'(r_rsum[2][k]);
            if (total[k][TOTAL_W-1:FRAC_W] > (TOTAL_W-FRAC_W)'(CHAN_MAX)) begin
                chan[k] = CHAN_MAX;
            end else begin
                chan[k] = total[k][FRAC_W +: CHAN_W];
            end
        end
    end

    assign o_res.red   = chan[2];
    assign o_res.green = chan[1];
    assign o_res.blue  = chan[0];
    assign o_res.eof   = r_tag.eof;
    assign o_push      = r_tag.valid && r_tag.have;

endmodule

`default_nettype wire

// ----- hdl/gaussian_blur_3x3_rgb.sv -----
// Pipeline: line memory read, window shift, weighted taps and row sums; a result is
//   released by the request arriving one line plus one pixel after the pixel itself.
// Throughput: one request per cycle; ready drops only while two results wait in
//   the output queue.
// Reset: synchronous, active low; clears counters and window, loads the default
//   weights and frame size. The line memories are not cleared, so no startup delay.
// ----------------------------------------------------------------------------
// gaussian_blur_3x3_rgb
// Streaming 3x3 blur over RGBA pixels with line memories and a 3x3 grid of
// window cells, saturated 8-bit output and an opaque alpha.
// ----------------------------------------------------------------------------
`default_nettype none

`include "gaussian_blur_3x3_rgb_assert.svh"

module gaussian_blur_3x3_rgb import gb3_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    gb3_pix_in_if.sink            i_pix,
    gb3_pix_out_if.source         o_blur,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    // configuration
    logic [WGT_W-1:0] r_w_corner, r_w_edge, r_w_center;
    logic [DIM_W-1:0] r_frame_width, r_frame_height;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_w_corner     <= RST_W_CORNER;
            r_w_edge       <= RST_W_EDGE;
            r_w_center     <= RST_W_CENTER;
            r_frame_width  <= RST_WIDTH;
            r_frame_height <= RST_HEIGHT;
        end else if (i_cfg_we) begin
            case (t_reg_idx'(i_cfg_index))
                REG_W_CORNER:     r_w_corner     <= i_cfg_data;
                REG_W_EDGE:       r_w_edge       <= i_cfg_data;
                REG_W_CENTER:     r_w_center     <= i_cfg_data;
                REG_FRAME_WIDTH:  r_frame_width  <= i_cfg_data[DIM_W-1:0];
                REG_FRAME_HEIGHT: r_frame_height <= i_cfg_data[DIM_W-1:0];
                default: ;
            endcase
        end
    end

    // pipeline advance and output queue
    logic       adv;
    logic       accept;
    logic [1:0] r_cnt, n_cnt;
    t_res       r_q0, r_q1, n_q0, n_q1;
    logic       pop;
    logic       push;
    t_res       push_res;
    logic [1:0] wr_idx;

    assign adv          = (r_cnt != 2'd2);
    assign i_pix.ready  = adv;
    assign accept       = i_pix.valid && adv;

    // position of the incoming request
    logic [COL_W-1:0] r_col, n_col;
    logic [ROW_W-1:0] r_row, n_row;
    logic [DIM_W-1:0] w_use, h_use;
    logic [DIM_W-1:0] col0, cx, cy, col_inc;
    logic [ROW_W-1:0] row0;
    logic             row_big;
    t_pos             pos;
    t_pix             now;

    assign w_use = clamp_dim(r_frame_width, DIM_W'(MAX_WIDTH));
    assign h_use = clamp_dim(r_frame_height, DIM_W'(MAX_HEIGHT));
    assign now   = i_pix.command ? '0 : i_pix.pixel_word[WORD_W-1 -: PIX_W];

    always_comb begin
        row_big = {1'b0, r_row} > ({1'b0, h_use} + 1'b1);
        col0    = (row_big || DIM_W'(r_col) >= w_use) ? '0 : DIM_W'(r_col);
        row0    = row_big ? '0 : r_row;

        // the window centre trails the request by one line plus one pixel
        if (col0 != '0) begin
            pos.have = (row0 >= ROW_W'(1)) && (row0 <= ROW_W'(h_use));
            cy       = DIM_W'(row0 - ROW_W'(1));
            cx       = col0 - DIM_W'(1);
        end else begin
            pos.have = (row0 >= ROW_W'(2)) && ({1'b0, row0} <= ({1'b0, h_use} + 1'b1));
            cy       = DIM_W'(row0 - ROW_W'(2));
            cx       = w_use - DIM_W'(1);
        end
        pos.top    = (cy == '0);
        pos.bottom = (cy == h_use - DIM_W'(1));
        pos.left   = (cx == '0);
        pos.right  = (cx == w_use - DIM_W'(1));
        pos.eof    = pos.right && pos.bottom;

        col_inc = col0 + DIM_W'(1);
        if (col_inc >= w_use) begin
            n_col = '0;
            n_row = row0 + ROW_W'(1);
        end else begin
            n_col = col_inc[COL_W-1:0];
            n_row = row0;
        end
        if (pos.have && pos.eof) begin
            n_col = '0;
            n_row = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
        end else if (accept) begin
            r_col <= n_col;
            r_row <= n_row;
        end
    end

    // stage 1: line memory read
    logic             r_s1_valid;
    logic [COL_W-1:0] r_s1_col;
    t_pos             r_s1_pos;
    t_pix             r_s1_now;
    t_pix             up_pix, lo_pix;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (adv) begin
            r_s1_valid <= accept;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_col <= col0[COL_W-1:0];
            r_s1_pos <= pos;
            r_s1_now <= now;
        end
    end

    gb3_line_store u_lines (
        .i_clk     (i_clk),
        .i_rd_en   (accept),
        .i_rd_addr (col0[COL_W-1:0]),
        .i_now     (now),
        .i_wb_en   (adv && r_s1_valid),
        .i_wb_addr (r_s1_col),
        .o_up      (up_pix),
        .o_lo      (lo_pix)
    );

    // stage 2: window cells shift, stage 3: weighted taps
    logic   r_s2_valid;
    t_pos   r_s2_pos;
    t_tag   r_s3_tag;
    t_pix   row_in [3];
    t_pix   win    [3][3];
    t_prod3 [8:0] prod;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_valid <= 1'b0;
            r_s3_tag   <= '0;
        end else if (adv) begin
            r_s2_valid <= r_s1_valid;
            r_s3_tag   <= '{valid: r_s2_valid, have: r_s2_pos.have, eof: r_s2_pos.eof};
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_s2_pos <= r_s1_pos;
        end
    end

    assign row_in[0] = up_pix;
    assign row_in[1] = lo_pix;
    assign row_in[2] = r_s1_now;

    for (genvar r = 0; r < 3; r++) begin : g_row
        for (genvar c = 0; c < 3; c++) begin : g_col
            logic [WGT_W-1:0] wgt;
            logic             keep;
            t_pix             pin;

            if (r == 1 && c == 1) begin : g_center
                assign wgt = r_w_center;
            end else if (r == 1 || c == 1) begin : g_edge
                assign wgt = r_w_edge;
            end else begin : g_corner
                assign wgt = r_w_corner;
            end

            if (c == 2) begin : g_feed
                assign pin = row_in[r];
            end else begin : g_pass
                assign pin = win[r][c+1];
            end

            assign keep = !((r == 0) && r_s2_pos.top) && !((r == 2) && r_s2_pos.bottom)
                       && !((c == 0) && r_s2_pos.left) && !((c == 2) && r_s2_pos.right);

            gb3_cell u_cell (
                .i_clk    (i_clk),
                .i_rst_n  (i_rst_n),
                .i_shift  (adv && r_s1_valid),
                .i_en     (adv),
                .i_pix    (pin),
                .o_pix    (win[r][c]),
                .i_weight (wgt),
                .i_keep   (keep),
                .o_prod   (prod[r*3+c])
            );
        end
    end

    // stage 4: row sums, then total and saturate into the output queue
    gb3_sum u_sum (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (adv),
        .i_tag   (r_s3_tag),
        .i_prod  (prod),
        .o_res   (push_res),
        .o_push  (push)
    );

    assign pop    = o_blur.valid && o_blur.ready;
    assign wr_idx = r_cnt - {1'b0, pop};

    always_comb begin
        n_q0  = r_q0;
        n_q1  = r_q1;
        n_cnt = r_cnt - {1'b0, pop};
        if (pop) begin
            n_q0 = r_q1;
        end
        if (adv && push) begin
            n_cnt = n_cnt + 2'd1;
            if (wr_idx == 2'd0) begin
                n_q0 = push_res;
            end else begin
                n_q1 = push_res;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else begin
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_q0 <= n_q0;
        r_q1 <= n_q1;
    end

    assign o_blur.valid        = (r_cnt != 2'd0);
    assign o_blur.red          = r_q0.red;
    assign o_blur.green        = r_q0.green;
    assign o_blur.blue         = r_q0.blue;
    assign o_blur.alpha        = ALPHA_OPAQUE;
    assign o_blur.end_of_frame = r_q0.eof;

    // a request that releases the frame's last pixel restarts the raster
    `GB3_ASSERT_NEXT(a_eof_restart, i_clk, i_rst_n, accept && pos.have && pos.eof, r_col == '0 && r_row == '0)
    // window shift and line write-back always hand the request on
    `GB3_ASSERT_NEXT(a_s1_moves, i_clk, i_rst_n, adv && r_s1_valid, r_s2_valid)
    // a full queue freezes the window stage
    `GB3_ASSERT_NEXT(a_stall_holds, i_clk, i_rst_n, !adv, $stable(r_s2_valid))
    // the queue never fills past two
    `GB3_ASSERT_NOW(a_queue_bound, i_clk, i_rst_n, push && adv, r_cnt != 2'd2)

endmodule

`default_nettype wire

// ----- test/tb_gaussian_blur_3x3_rgb.sv -----
// ----------------------------------------------------------------------------
// tb_gaussian_blur_3x3_rgb
// Self-checking bench for the streaming 3x3 RGB blur. A per-request predictor
// tracks line stores, window and counters. Expected pixels are queued per
// accepted request and compared field by field with each output request.
// Traffic is mostly whole frames with flush tails, with some noise and some
// mid-frame reconfiguration, under random stalls on both channels.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_gaussian_blur_3x3_rgb;
    import gb3_pkg::*;

    localparam int          CLK_HALF      = 5;
    localparam int          RST_CYCLES    = 11;
    localparam int          IDLE_PCT      = 18;
    localparam int          SETTLE_CYCLES = 12;
    localparam int          HOLD_CYCLES   = 300;
    localparam int          RANDOM_ITEMS  = 140;
    localparam int          MIN_DIM       = 3;
    localparam int unsigned RUN_LIMIT     = 250000;

    typedef struct {
        t_chan red;
        t_chan green;
        t_chan blue;
        t_chan alpha;
        logic  eof;
    } t_blurred_px;

    logic clk = 1'b0;
    logic rst_n;

    gb3_pix_in_if  pix_if ();
    gb3_pix_out_if blur_if ();

    logic                  cfg_we;
    t_reg_idx              cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    // predictor state
    logic [WGT_W-1:0] wt_corner, wt_side, wt_mid;
    logic [DIM_W-1:0] width_reg, height_reg;
    t_pix             line_upper [MAX_WIDTH];
    t_pix             line_lower [MAX_WIDTH];
    t_pix             win        [3][3];
    int               col_pos, row_pos;
    bit               frame_done;

    t_blurred_px blur_expected [$];
    t_blurred_px head_px;

    int          mismatch_count = 0;
    int unsigned cycle_count    = 0;
    int          items_sent     = 0;
    bit          idle_on        = 1'b1;
    bit          hold_request   = 1'b0;
    int          hold_left      = 0;

    gaussian_blur_3x3_rgb DUT (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_pix       (pix_if),
        .o_blur      (blur_if),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    always #CLK_HALF clk = ~clk;

    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= RUN_LIMIT) begin
            $display("TIMEOUT after %0d cycles", cycle_count);
            $display("Mismatches found");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------------
    function automatic int fit_dim(logic [DIM_W-1:0] v, int hi);
        if (v < MIN_DIM) return MIN_DIM;
        if (v > hi) return hi;
        return int'(v);
    endfunction

    function automatic t_chan blur_chan(int sh, bit top, bit bot, bit lft, bit rgt);
        logic [31:0]      acc;
        logic [WGT_W-1:0] wt;
        int               r, c;
        acc = '0;
        for (r = 0; r < 3; r++) begin
            for (c = 0; c < 3; c++) begin
                if (!((r == 0 && top) || (r == 2 && bot) || (c == 0 && lft) || (c == 2 && rgt))) begin
                    if (r == 1 && c == 1) wt = wt_mid;
                    else if (r == 1 || c == 1) wt = wt_side;
                    else wt = wt_corner;
                    acc += 32'(win[r][c][sh +: CHAN_W]) * 32'(wt);
                end
            end
        end
        acc = acc >> FRAC_W;
        return (acc > 32'd255) ? CHAN_MAX : acc[CHAN_W-1:0];
    endfunction

    function automatic void reset_model();
        int i, r;
        wt_corner  = RST_W_CORNER;
        wt_side    = RST_W_EDGE;
        wt_mid     = RST_W_CENTER;
        width_reg  = RST_WIDTH;
        height_reg = RST_HEIGHT;
        for (i = 0; i < MAX_WIDTH; i++) begin
            line_upper[i] = '0;
            line_lower[i] = '0;
        end
        for (r = 0; r < 3; r++) win[r] = '{'0, '0, '0};
        col_pos = 0;
        row_pos = 0;
    endfunction

    task automatic predict_item(bit cmd, logic [WORD_W-1:0] word);
        int          w, h, col, row, cx, cy, r;
        t_pix        now, up, lo;
        bit          have, top, bot, lft, rgt;
        t_blurred_px px;
        w = fit_dim(width_reg, MAX_WIDTH);
        h = fit_dim(height_reg, MAX_HEIGHT);
        if (col_pos >= w) col_pos = 0;
        if (row_pos > h + 1) begin
            row_pos = 0;
            col_pos = 0;
        end
        col = col_pos;
        row = row_pos;

        now = cmd ? '0 : word[WORD_W-1:CHAN_W];
        up  = line_upper[col];
        lo  = line_lower[col];
        line_upper[col] = lo;
        line_lower[col] = now;
        for (r = 0; r < 3; r++) begin
            win[r][0] = win[r][1];
            win[r][1] = win[r][2];
        end
        win[0][2] = up;
        win[1][2] = lo;
        win[2][2] = now;

        // centre trails the incoming request by one line plus one pixel
        if (col >= 1) begin
            cx   = col - 1;
            cy   = row - 1;
            have = row >= 1 && row - 1 < h;
        end else begin
            cx   = w - 1;
            cy   = row - 2;
            have = row >= 2 && row - 2 < h;
        end

        col_pos = col + 1;
        if (col_pos >= w) begin
            col_pos = 0;
            row_pos = row + 1;
        end

        if (have) begin
            top = cy == 0;
            bot = cy == h - 1;
            lft = cx == 0;
            rgt = cx == w - 1;
            px.red   = blur_chan(16, top, bot, lft, rgt);
            px.green = blur_chan(8, top, bot, lft, rgt);
            px.blue  = blur_chan(0, top, bot, lft, rgt);
            px.alpha = ALPHA_OPAQUE;
            px.eof   = rgt && bot;
            blur_expected.push_back(px);
            if (px.eof) begin
                col_pos    = 0;
                row_pos    = 0;
                frame_done = 1'b1;
            end
        end
    endtask

    // next request lands inside the frame rows (not in the flush tail)
    function automatic bit next_in_rows();
        int h, r;
        h = fit_dim(height_reg, MAX_HEIGHT);
        r = (row_pos > h + 1) ? 0 : row_pos;
        return r < h;
    endfunction

    // ------------------------------------------------------------------------
    // Checking
    // ------------------------------------------------------------------------
    task automatic report_mismatch(string what);
        $display("ERROR cycle %0d: %s", cycle_count, what);
        mismatch_count++;
    endtask

    task automatic check_field(string name, logic [CHAN_W-1:0] got, logic [CHAN_W-1:0] want);
        if (got !== want)
            report_mismatch($sformatf("%s got %0h, expected %0h", name, got, want));
    endtask

    always @(posedge clk) begin
        if (rst_n && blur_if.valid && blur_if.ready) begin
            if (blur_expected.size() == 0) begin
                report_mismatch("output request with nothing expected");
            end else begin
                head_px = blur_expected.pop_front();
                check_field("red", blur_if.red, head_px.red);
                check_field("green", blur_if.green, head_px.green);
                check_field("blue", blur_if.blue, head_px.blue);
                check_field("alpha", blur_if.alpha, head_px.alpha);
                check_field("end_of_frame", CHAN_W'(blur_if.end_of_frame), CHAN_W'(head_px.eof));
            end
        end
    end

    // output side: random stalls, plus a long hold-off on request
    always @(negedge clk) begin
        if (hold_request) begin
            hold_request = 1'b0;
            hold_left    = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left--;
            blur_if.ready <= 1'b0;
        end else begin
            blur_if.ready <= !(idle_on && $urandom_range(99) < IDLE_PCT);
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus helpers (entered and left at a falling edge)
    // ------------------------------------------------------------------------
    task automatic send_item(bit cmd, logic [WORD_W-1:0] word);
        while (idle_on && $urandom_range(99) < IDLE_PCT) begin
            pix_if.valid <= 1'b0;
            @(negedge clk);
        end
        pix_if.valid      <= 1'b1;
        pix_if.command    <= cmd;
        pix_if.pixel_word <= word;
        do @(posedge clk); while (!pix_if.ready);
        predict_item(cmd, word);
        items_sent++;
        @(negedge clk);
    endtask

    task automatic drain_block();
        pix_if.valid <= 1'b0;
        while (blur_expected.size() != 0) @(posedge clk);
        // a request that releases no pixel may still be in flight
        repeat (SETTLE_CYCLES) @(posedge clk);
        @(negedge clk);
    endtask

    task automatic load_config(input logic [CFG_DATA_W-1:0] w_corner, w_side, w_mid,
                               width_val, height_val);
        t_reg_idx              regs_in_order [5];
        logic [CFG_DATA_W-1:0] vals          [5];
        int                    k;
        regs_in_order = '{REG_W_CORNER, REG_W_EDGE, REG_W_CENTER,
                          REG_FRAME_WIDTH, REG_FRAME_HEIGHT};
        vals = '{w_corner, w_side, w_mid, width_val, height_val};
        for (k = 0; k < 5; k++) begin
            cfg_we    <= 1'b1;
            cfg_index <= regs_in_order[k];
            cfg_data  <= vals[k];
            @(negedge clk);
        end
        cfg_we <= 1'b0;
        wt_corner  = w_corner;
        wt_side    = w_side;
        wt_mid     = w_mid;
        width_reg  = width_val[DIM_W-1:0];
        height_reg = height_val[DIM_W-1:0];
    endtask

    // Sends requests until the predictor sees the frame end. flush_pct: flush
    // requests inside the frame; word_pct: pixel words in the flush tail.
    // At break_at the block is drained and one dimension is cut down.
    task automatic send_frame(int flush_pct, int word_pct, int break_at,
                              bit cut_width, int new_dim);
        int n;
        n          = 0;
        frame_done = 1'b0;
        while (!frame_done) begin
            if (n == break_at) begin
                drain_block();
                if (cut_width)
                    load_config(wt_corner, wt_side, wt_mid, CFG_DATA_W'(new_dim),
                                CFG_DATA_W'(height_reg));
                else
                    load_config(wt_corner, wt_side, wt_mid, CFG_DATA_W'(width_reg),
                                CFG_DATA_W'(new_dim));
            end
            if (next_in_rows())
                send_item($urandom_range(99) < flush_pct, $urandom);
            else
                send_item($urandom_range(99) >= word_pct, $urandom);
            n++;
        end
    endtask

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------
    task automatic test_directed_extremes();
        logic [WORD_W:0] seq [13];
        int              i;
        // {command, pixel_word}; 3x3 frame, then the four-request flush tail
        seq = '{{1'b0, 32'hFFFF_FFFF}, {1'b0, 32'h0000_0000}, {1'b0, 32'hFFFF_FF55},
                {1'b0, 32'h8080_8080}, {1'b1, 32'hFFFF_FFFF}, {1'b0, 32'h0102_03AA},
                {1'b0, 32'hFF00_FF00}, {1'b0, 32'h00FF_00FF}, {1'b0, 32'h7F7F_7F7F},
                {1'b1, 32'h0000_0000}, {1'b0, 32'hFFFF_FFFF}, {1'b1, 32'h1234_5678},
                {1'b1, 32'hFFFF_FFFF}};
        // full weights saturate; dims below range clamp up to 3
        load_config(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'd0, 16'd1);
        for (i = 0; i < 13; i++) send_item(seq[i][WORD_W], seq[i][WORD_W-1:0]);
        drain_block();

        load_config(16'd0, 16'hFFFF, 16'd1, 16'd2, 16'd3);
        send_frame(0, 0, -1, 1'b0, 0);
        drain_block();
    endtask

    task automatic test_midframe_reconfig();
        // height cut below the current row restarts the frame
        load_config(RST_W_CORNER, RST_W_EDGE, RST_W_CENTER, 16'd6, 16'd6);
        send_frame(0, 0, 32, 1'b0, 3);
        drain_block();
        // width cut below the current column wraps it to zero
        load_config(RST_W_CORNER, RST_W_EDGE, RST_W_CENTER, 16'd8, 16'd5);
        send_frame(0, 0, 22, 1'b1, 4);
        drain_block();
    endtask

    task automatic test_output_backpressure();
        idle_on = 1'b0;
        load_config(RST_W_CORNER, RST_W_EDGE, RST_W_CENTER, 16'd8, 16'd4);
        @(posedge clk);
        hold_request = 1'b1;
        @(negedge clk);
        send_frame(0, 0, -1, 1'b0, 0);
        drain_block();
        idle_on = 1'b1;
    endtask

    task automatic test_random_frames();
        logic [CFG_DATA_W-1:0] wc, ws, wm, wd, ht;
        int                    w, h, brk;
        items_sent = 0;
        while (items_sent < RANDOM_ITEMS) begin
            // one long stretch with no stalls on either side
            idle_on = !(items_sent >= 40 && items_sent < 100);
            case ($urandom_range(2))
                0: begin
                    wc = CFG_DATA_W'($urandom_range(16'hFFFF));
                    ws = CFG_DATA_W'($urandom_range(16'hFFFF));
                    wm = CFG_DATA_W'($urandom_range(16'hFFFF));
                end
                1: begin
                    wc = CFG_DATA_W'($urandom_range(2048, 6144));
                    ws = CFG_DATA_W'($urandom_range(4096, 12288));
                    wm = CFG_DATA_W'($urandom_range(8192, 24576));
                end
                default: begin
                    wc = $urandom_range(1) ? 16'hFFFF : 16'h0000;
                    ws = $urandom_range(1) ? 16'hFFFF : 16'h0000;
                    wm = $urandom_range(1) ? 16'hFFFF : 16'h0000;
                end
            endcase
            wd = CFG_DATA_W'(($urandom_range(9) == 0) ? $urandom_range(2)
                                                     : $urandom_range(3, 12));
            ht = CFG_DATA_W'(($urandom_range(9) == 0) ? $urandom_range(2)
                                                     : $urandom_range(3, 8));
            load_config(wc, ws, wm, wd, ht);
            w   = fit_dim(width_reg, MAX_WIDTH);
            h   = fit_dim(height_reg, MAX_HEIGHT);
            brk = ($urandom_range(4) == 0) ? $urandom_range(1, w * h + w) : -1;
            if ($urandom_range(1))
                send_frame(5, 10, brk, 1'b1, $urandom_range(MIN_DIM, w));
            else
                send_frame(5, 10, brk, 1'b0, $urandom_range(MIN_DIM, h));
            drain_block();
        end
        idle_on = 1'b1;
    endtask

    task automatic test_clamped_large_frames();
        // width register above range clamps to the full line length; once the
        // first line has wrapped the line is cut short to finish the frame
        load_config(RST_W_CORNER, RST_W_EDGE, RST_W_CENTER, 16'hFFFF, 16'd3);
        send_frame(2, 5, MAX_WIDTH + 2, 1'b1, MIN_DIM);
        drain_block();
        // height register above range; the frame is cut short early
        load_config(RST_W_CORNER, RST_W_EDGE, RST_W_CENTER, 16'd3, 16'd1025);
        send_frame(2, 5, 8, 1'b0, 4);
        drain_block();
    endtask

    initial begin
        rst_n             = 1'b0;
        pix_if.valid      = 1'b0;
        pix_if.command    = 1'b0;
        pix_if.pixel_word = '0;
        blur_if.ready     = 1'b0;
        cfg_we            = 1'b0;
        cfg_index         = REG_W_CORNER;
        cfg_data          = '0;
        reset_model();

        repeat (RST_CYCLES) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        test_directed_extremes();
        test_midframe_reconfig();
        test_output_backpressure();
        test_random_frames();
        test_clamped_large_frames();

        drain_block();
        if (blur_expected.size() != 0)
            report_mismatch($sformatf("%0d expected pixels never came", blur_expected.size()));
        if (mismatch_count == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule

`default_nettype wire

// ----- sim.f -----
+incdir+hdl
hdl/gb3_pkg.sv
hdl/gb3_pix_in_if.sv
hdl/gb3_pix_out_if.sv
hdl/gb3_line_store.sv
hdl/gb3_cell.sv
hdl/gb3_sum.sv
hdl/gaussian_blur_3x3_rgb.sv
test/tb_gaussian_blur_3x3_rgb.sv
